// ----- rtl/ust_pkg.sv -----
// ust_pkg: shared constants, operation codes and control/status structs
// for the unordered set table; used by the controller, datapath and top level
package ust_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = 5;
   localparam int CAP_W       = 5;
   localparam int VALUE_W     = 32;
   localparam int OP_W        = 2;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_LSB = 2;
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef struct packed {
      logic start;
      logic scan;
      logic hit;
      logic append;
      logic reject;
      logic fetch_last;
      logic move;
      logic load_rsp;
   } ust_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic match;
      logic scan_last;
      logic is_insert;
      logic is_delete;
      logic found;
      logic can_append;
      logic rsp_busy;
   } ust_status_type;

endpackage

// ----- rtl/ust_ctrl.sv -----
// ust_ctrl: sequencing state machine for the unordered set table
// depends on ust_pkg for the command and status structs
module ust_ctrl import ust_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ust_status_type status,
   output ust_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_ACT    = 3'd2;
   localparam logic [2:0] S_MOVE   = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = status.count_zero ? S_ACT : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.match) begin
               cmd.hit  = 1'b1;
               state_in = S_ACT;
            end else if (status.scan_last) begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            state_in = S_RESULT;
            if (status.is_insert && !status.found) begin
               if (status.can_append) begin
                  cmd.append = 1'b1;
               end else begin
                  cmd.reject = 1'b1;
               end
            end else if (status.is_delete && status.found) begin
               cmd.fetch_last = 1'b1;
               state_in       = S_MOVE;
            end
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/ust_dp.sv -----
// ust_dp: entry memory, count, scan pointers and result register
// depends on ust_pkg; driven by ust_ctrl through command and status structs
module ust_dp import ust_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ust_cmd_type               cmd,
   output ust_status_type            status,
   input  logic [CAP_W-1:0]          cap_limit,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COUNT_W-1:0]        rsp_position,
   output logic                      rsp_found,
   output logic                      rsp_rejected,
   output logic [COUNT_W-1:0]        rsp_count_after
);

   logic [VALUE_W-1:0] mem [MAX_ENTRIES];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;

   logic [OP_W-1:0]    op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] issue_ff, issue_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [COUNT_W-1:0] pos_ff, pos_in;
   logic               found_ff, found_in;
   logic               rejected_ff, rejected_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_rej_ff, rsp_rej_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic [COUNT_W-1:0] count_dec;
   logic [COUNT_W-1:0] cmp_next;
   logic [CAP_W-1:0]   eff_cap;

   assign count_dec = count_ff - COUNT_W'(1);
   assign cmp_next  = COUNT_W'(cmp_idx_ff) + COUNT_W'(1);
   assign eff_cap   = (cap_limit > CAP_W'(MAX_ENTRIES)) ? CAP_W'(MAX_ENTRIES) : cap_limit;

   assign rd_addr = cmd.fetch_last ? count_dec[IDX_W-1:0] : issue_ff[IDX_W-1:0];
   assign wr_en   = cmd.append || cmd.move;
   assign wr_addr = cmd.move ? pos_ff[IDX_W-1:0] : count_ff[IDX_W-1:0];
   assign wr_data = cmd.move ? rd_data_ff : value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      op_in        = op_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      rejected_in  = rejected_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_found_in = rsp_found_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      if (cmd.start) begin
         op_in        = req_operation;
         value_in     = req_value;
         issue_in     = '0;
         cmp_valid_in = 1'b0;
         pos_in       = count_ff;
         found_in     = 1'b0;
         rejected_in  = 1'b0;
      end
      if (cmd.scan) begin
         if (issue_ff < count_ff) begin
            issue_in     = issue_ff + COUNT_W'(1);
            cmp_idx_in   = issue_ff[IDX_W-1:0];
            cmp_valid_in = 1'b1;
         end else begin
            cmp_valid_in = 1'b0;
         end
      end
      if (cmd.hit) begin
         found_in = 1'b1;
         pos_in   = COUNT_W'(cmp_idx_ff);
      end
      if (cmd.reject) begin
         rejected_in = 1'b1;
      end
      if (cmd.append) begin
         count_in = count_ff + COUNT_W'(1);
      end
      if (cmd.move) begin
         count_in = count_dec;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pos_ff;
         rsp_found_in = found_ff;
         rsp_rej_in   = rejected_ff;
         rsp_cnt_in   = count_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      value_ff     <= value_in;
      issue_ff     <= issue_in;
      cmp_idx_ff   <= cmp_idx_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      rejected_ff  <= rejected_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign status.count_zero = (count_ff == '0);
   assign status.match      = cmp_valid_ff && (rd_data_ff == value_ff);
   assign status.scan_last  = cmp_valid_ff && (cmp_next == count_ff);
   assign status.is_insert  = (op_ff == OP_INSERT);
   assign status.is_delete  = (op_ff == OP_DELETE);
   assign status.found      = found_ff;
   assign status.can_append = (count_ff < eff_cap);
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_rejected    = rsp_rej_ff;
   assign rsp_count_after = rsp_cnt_ff;

endmodule

// ----- rtl/unordered_set_table.sv -----
// unordered_set_table: top level with the capacity register port and checks
// depends on ust_pkg, ust_ctrl and ust_dp
//
// Holds up to 16 distinct 32-bit values in an unordered memory with one
// write port and one read port. Each item is a lookup, insert or delete
// and gets exactly one result. The stored entries are compared one per
// cycle through the registered read port; the scan stops at a match or at
// the last entry. A delete that hits then moves the last entry into the
// freed slot, and an empty set skips the scan. The next item is taken once
// the result is in the output register, even while that result still
// waits to be taken. capacity_limit sits at byte address 0 and resets to 16.
module unordered_set_table import ust_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COUNT_W-1:0]        rsp_position,
   output logic                      rsp_found,
   output logic                      rsp_rejected,
   output logic [COUNT_W-1:0]        rsp_count_after,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   ust_cmd_type    cmd;
   ust_status_type status;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             cap_sel;

   assign cap_sel    = (csr_paddr[CSR_IDX_LSB] == CSR_IDX_CAPACITY);
   assign csr_pready = 1'b1;
   assign csr_prdata = cap_sel ? CSR_DATA_W'(cap_ff) : '0;

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && cap_sel) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   ust_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ust_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cap_limit       (cap_ff),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_found       (rsp_found),
      .rsp_rejected    (rsp_rejected),
      .rsp_count_after (rsp_count_after)
   );

`ifndef SYNTHESIS
   a_rej_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_rejected && rsp_found))
      else $error("rejected result also marked found");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count_after <= COUNT_W'(MAX_ENTRIES)))
      else $error("count beyond store depth");

   a_found_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_position < COUNT_W'(MAX_ENTRIES)))
      else $error("found position outside store");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while first in flight");
`endif

endmodule
